// File: src/direct_mapped_hash_table_resize_macros.svh
// assertion macros for the direct-mapped hash table checker
// no dependencies; included by the checker file only
`ifndef DIRECT_MAPPED_HASH_TABLE_RESIZE_MACROS_SVH
`define DIRECT_MAPPED_HASH_TABLE_RESIZE_MACROS_SVH

// same-cycle implication, masked during reset
`define DMHT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, masked during reset
`define DMHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

// next-cycle implication that also holds across reset
`define DMHT_ASSERT_NEXT_ANY(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// File: src/dmht_pkg.sv
// shared types and constants of the direct-mapped hash table
// no dependencies; imported by the modulo unit and the top level
package dmht_pkg;

  localparam int KEY_W   = 64;
  localparam int PRICE_W = 32;
  localparam int CFG_W   = 9;
  localparam int BYTE_W  = 8;

  // the modulo unit retires two dividend bits per cycle
  localparam int MOD_STEPS  = 4;
  localparam int MOD_STEP_W = 2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // modulo unit status toward the controller
  typedef struct packed {
    logic              done;
    logic [BYTE_W-1:0] rem;
  } mod_res_t;

endpackage

// File: src/direct_mapped_hash_table_resize.sv
// Direct-mapped price table, one entry per bucket, bucket = first name byte
// mod the live bucket count. After reset and after every configuration write
// the block sweeps all MAX_BUCKETS entries of the table RAM with in_stall
// high. A plain insert, delete or lookup then waits in S_MOD on the radix-4
// modulo unit, reads the table RAM through its registered read port in S_RD
// and updates the entry in S_EXEC; the block then returns to S_IDLE for the
// next item, so one item is in work at a time. A result that waits at the
// output does not block the next item, but a second finished result is held
// and keeps in_stall high until the first is taken. An insert that finds the
// table half full, where the doubled count still fits in MAX_BUCKETS, first
// doubles it by walking the old buckets: every occupied entry's new bucket
// goes through the modulo unit, and an entry that moves costs two RAM writes,
// one to its new bucket and one to clear the old.
// depends on dmht_pkg, dmht_ram, dmht_mod
module direct_mapped_hash_table_resize import dmht_pkg::*; #(
  parameter int MAX_BUCKETS = 256,
  parameter int NAME_BYTES  = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [CFG_W-1:0]                    cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          op,
  input  logic [KEY_W-1:0]                    key_name,
  input  logic [PRICE_W-1:0]                  price_cents,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                found,
  output logic [KEY_W-1:0]                    out_name,
  output logic [PRICE_W-1:0]                  out_price_cents,
  output logic [$clog2(MAX_BUCKETS+1)-1:0]    bucket_total
);

  localparam int NAME_W = 8 * NAME_BYTES;
  localparam int ADDR_W = $clog2(MAX_BUCKETS);
  localparam int CNT_W  = $clog2(MAX_BUCKETS + 1);
  localparam int ENT_W  = 1 + NAME_W + PRICE_W;
  localparam int CW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_WRD   = 11'b000_0000_0100,
    S_WCHK  = 11'b000_0000_1000,
    S_WMOD  = 11'b000_0001_0000,
    S_WMV   = 11'b000_0010_0000,
    S_WCLR  = 11'b000_0100_0000,
    S_WNEXT = 11'b000_1000_0000,
    S_MOD   = 11'b001_0000_0000,
    S_RD    = 11'b010_0000_0000,
    S_EXEC  = 11'b100_0000_0000
  } state_t;

  // an extra state for result hand-off
  typedef enum logic [1:0] {
    H_EMPTY = 2'b01,
    H_FULL  = 2'b10
  } hold_t;

  function automatic logic [CNT_W-1:0] clamp_buckets(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (CW'(v) > CW'(MAX_BUCKETS)) begin
      r = CNT_W'(MAX_BUCKETS);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  state_t            state;
  hold_t             hold;
  logic [CNT_W-1:0]  live;
  logic [CNT_W-1:0]  filled;
  logic [CNT_W-1:0]  old_buckets;
  logic [CNT_W-1:0]  walk_cnt;
  logic [ADDR_W-1:0] walk_idx;
  logic [ADDR_W-1:0] clr_idx;

  op_t                op_r;
  logic [NAME_W-1:0]  key_r;
  logic [PRICE_W-1:0] price_r;
  logic [ENT_W-1:0]   walk_ent;
  logic               res_found;
  logic [NAME_W-1:0]  res_name;
  logic [PRICE_W-1:0] res_price;

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENT_W-1:0]   wr_data;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ENT_W-1:0]   rd_data;

  logic               mod_start;
  logic [BYTE_W-1:0]  mod_dvd;
  mod_res_t           mod_res;
  logic [ADDR_W-1:0]  rem_addr;

  logic               rd_valid;
  logic [NAME_W-1:0]  rd_name;
  logic [PRICE_W-1:0] rd_price;
  logic [NAME_W-1:0]  in_key;
  logic               resize_cond;
  logic               resize_go;
  logic               walk_last;
  logic               out_free;
  logic               exec_found;

  // table ram: {valid, name, price} per bucket
  dmht_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // bucket index unit
  dmht_mod #(
    .DIV_W (CNT_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (live),
    .res      (mod_res)
  );

  // decode of read data and helper terms
  assign rd_valid    = rd_data[ENT_W-1];
  assign rd_name     = rd_data[PRICE_W +: NAME_W];
  assign rd_price    = rd_data[PRICE_W-1:0];
  assign in_key      = key_name[NAME_W-1:0];
  assign rem_addr    = ADDR_W'({{ADDR_W{1'b0}}, mod_res.rem});
  assign resize_cond = ({filled, 1'b0} >= {1'b0, live}) &&
                       ({1'b0, live, 1'b0} <= (CNT_W + 2)'(MAX_BUCKETS));
  assign resize_go   = (op_t'(op) == OP_INSERT) && resize_cond;
  assign walk_last   = (CNT_W'(walk_idx) == old_buckets - CNT_W'(1));
  assign out_free    = !out_valid || !out_stall;
  assign in_stall    = (state != S_IDLE) || (hold == H_FULL);
  assign rd_addr     = (state == S_WRD) ? walk_idx : rem_addr;

  // result of the current operation from the stored entry
  always_comb begin
    unique case (op_r)
      OP_INSERT: exec_found = rd_valid;
      OP_DELETE: exec_found = rd_valid;
      OP_LOOKUP: exec_found = rd_valid && (rd_name == key_r);
      OP_NONE:   exec_found = 1'b0;
    endcase
  end

  // modulo unit start and dividend select
  always_comb begin
    mod_start = 1'b0;
    mod_dvd   = in_key[NAME_W-1 -: BYTE_W];
    unique case (state)
      S_IDLE: begin
        mod_start = in_valid && !in_stall && !resize_go;
      end
      S_WCHK: begin
        mod_start = rd_valid;
        mod_dvd   = rd_name[NAME_W-1 -: BYTE_W];
      end
      S_WNEXT: begin
        mod_start = walk_last;
        mod_dvd   = key_r[NAME_W-1 -: BYTE_W];
      end
      default: begin
      end
    endcase
  end

  // ram write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_idx;
    wr_data = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_WMV: begin
        wr_en   = 1'b1;
        wr_addr = rem_addr;
        wr_data = walk_ent;
      end
      S_WCLR: begin
        wr_en   = 1'b1;
        wr_addr = walk_idx;
      end
      S_EXEC: begin
        wr_addr = rem_addr;
        unique case (op_r)
          OP_INSERT: begin
            wr_en   = 1'b1;
            wr_data = {1'b1, key_r, price_r};
          end
          OP_DELETE: begin
            wr_en = 1'b1;
          end
          OP_LOOKUP, OP_NONE: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      hold        <= H_EMPTY;
      live        <= CNT_W'(1);
      filled      <= '0;
      old_buckets <= CNT_W'(1);
      walk_cnt    <= '0;
      walk_idx    <= '0;
      clr_idx     <= '0;
      out_valid   <= 1'b0;
    end else begin
      // output register hand-off
      if (out_free && (hold == H_FULL || (state == S_EXEC && !cfg_we))) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (hold == H_FULL && out_free) begin
        hold <= H_EMPTY;
      end

      if (cfg_we) begin
        live    <= clamp_buckets(cfg_wdata);
        filled  <= '0;
        clr_idx <= '0;
        state   <= S_CLEAR;
      end else begin
        unique case (state)
          S_CLEAR: begin
            clr_idx <= clr_idx + ADDR_W'(1);
            if (clr_idx == ADDR_W'(MAX_BUCKETS - 1)) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_valid && !in_stall) begin
              if (resize_go) begin
                old_buckets <= live;
                live        <= {live[CNT_W-2:0], 1'b0};
                walk_idx    <= '0;
                walk_cnt    <= '0;
                state       <= S_WRD;
              end else begin
                state <= S_MOD;
              end
            end
          end
          S_WRD: begin
            state <= S_WCHK;
          end
          S_WCHK: begin
            if (rd_valid) begin
              walk_cnt <= walk_cnt + CNT_W'(1);
              state    <= S_WMOD;
            end else begin
              state <= S_WNEXT;
            end
          end
          S_WMOD: begin
            if (mod_res.done) begin
              state <= (rem_addr != walk_idx) ? S_WMV : S_WNEXT;
            end
          end
          S_WMV: begin
            state <= S_WCLR;
          end
          S_WCLR: begin
            state <= S_WNEXT;
          end
          S_WNEXT: begin
            if (walk_last) begin
              filled <= walk_cnt;
              state  <= S_MOD;
            end else begin
              walk_idx <= walk_idx + ADDR_W'(1);
              state    <= S_WRD;
            end
          end
          S_MOD: begin
            if (mod_res.done) begin
              state <= S_RD;
            end
          end
          S_RD: begin
            state <= S_EXEC;
          end
          S_EXEC: begin
            // a fresh insert raises the fill count, saturating at the table size
            if (op_r == OP_INSERT && !rd_valid && filled < CNT_W'(MAX_BUCKETS)) begin
              filled <= filled + CNT_W'(1);
            end
            if (!out_free) begin
              hold <= H_FULL;
            end
            state <= S_IDLE;
          end
          default: begin
            state <= S_CLEAR;
          end
        endcase
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && !in_stall) begin
      op_r    <= op_t'(op);
      key_r   <= in_key;
      price_r <= price_cents;
    end
    if (state == S_WCHK) begin
      walk_ent <= rd_data;
    end
    if (state == S_EXEC) begin
      res_found <= exec_found;
      res_name  <= exec_found ? rd_name : '0;
      res_price <= exec_found ? rd_price : '0;
      if (out_free) begin
        found           <= exec_found;
        out_name        <= KEY_W'(exec_found ? rd_name : '0);
        out_price_cents <= exec_found ? rd_price : '0;
        bucket_total    <= live;
      end
    end
    if (hold == H_FULL && out_free) begin
      found           <= res_found;
      out_name        <= KEY_W'(res_name);
      out_price_cents <= res_price;
      bucket_total    <= live;
    end
  end

endmodule

// File: src/dmht_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module dmht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: src/dmht_mod.sv
// radix-4 restoring remainder of a name byte by the bucket count
// depends on dmht_pkg
module dmht_mod import dmht_pkg::*; #(
  parameter int DIV_W = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [BYTE_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output mod_res_t          res
);

  localparam int CW = (DIV_W > BYTE_W + 1) ? DIV_W : BYTE_W + 1;

  logic                  busy;
  logic                  done;
  logic [MOD_STEP_W-1:0] step;
  logic [BYTE_W-1:0]     dvd;
  logic [DIV_W-1:0]      dsr;
  logic [BYTE_W-1:0]     rem;

  logic [CW-1:0]     dsr_w;
  logic [CW-1:0]     t1;
  logic [CW-1:0]     t1_sub;
  logic [BYTE_W-1:0] r1;
  logic [CW-1:0]     t2;
  logic [CW-1:0]     t2_sub;
  logic [BYTE_W-1:0] r2;

  // two restoring steps; the partial remainder always stays below 256
  always_comb begin
    dsr_w  = CW'(dsr);
    t1     = CW'({rem, dvd[BYTE_W-1]});
    t1_sub = (t1 >= dsr_w) ? (t1 - dsr_w) : t1;
    r1     = t1_sub[BYTE_W-1:0];
    t2     = CW'({r1, dvd[BYTE_W-2]});
    t2_sub = (t2 >= dsr_w) ? (t2 - dsr_w) : t2;
    r2     = t2_sub[BYTE_W-1:0];
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && !start && (step == MOD_STEP_W'(MOD_STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + MOD_STEP_W'(1);
        if (step == MOD_STEP_W'(MOD_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[BYTE_W-3:0], 2'b00};
      rem <= r2;
    end
  end

  assign res.done = done;
  assign res.rem  = rem;

endmodule

// File: src/dmht_checker.sv
// port-level checks of the direct-mapped hash table, bound to the top level
// depends on direct_mapped_hash_table_resize_macros.svh
`include "direct_mapped_hash_table_resize_macros.svh"

module dmht_checker #(
  parameter int MAX_BUCKETS = 256
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             cfg_we,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             found,
  input logic [63:0]                      out_name,
  input logic [31:0]                      out_price_cents,
  input logic [$clog2(MAX_BUCKETS+1)-1:0] bucket_total
);

  localparam int CNT_W = $clog2(MAX_BUCKETS + 1);

  // a stalled item holds
  `DMHT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(found) && $stable(out_name) && $stable(out_price_cents) && $stable(bucket_total))

  // an item without a returned entry carries zero fields
  `DMHT_ASSERT_NOW(a_empty_zero, clk, rst, out_valid && !found, (out_name == '0) && (out_price_cents == '0))

  // bucket count stays within the table
  `DMHT_ASSERT_NOW(a_bucket_range, clk, rst, out_valid, (bucket_total != '0) && (bucket_total <= CNT_W'(MAX_BUCKETS)))

  // reset and a configuration write start the clearing sweep
  `DMHT_ASSERT_NEXT_ANY(a_clear_stall, clk, rst || cfg_we, in_stall)

endmodule

bind direct_mapped_hash_table_resize dmht_checker #(
  .MAX_BUCKETS (MAX_BUCKETS)
) u_dmht_checker (
  .clk             (clk),
  .rst             (rst),
  .cfg_we          (cfg_we),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .found           (found),
  .out_name        (out_name),
  .out_price_cents (out_price_cents),
  .bucket_total    (bucket_total)
);
